// ----- sv/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with sort.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_SWAP       = 3'd5;
    localparam logic [2:0] OP_SORT       = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [6:0]         index_a;
        logic [6:0]         index_b;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         count;
        logic [1:0]         status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SWP_B,
        S_SWP_WA,
        S_SWP_WB,
        S_SRT_PASS,
        S_SRT_LOAD,
        S_SRT_RD,
        S_SRT_CMP,
        S_SRT_TAIL
    } t_state;

endpackage

// ----- sv/bdq_store.sv -----
// ----------------------------------------------------------------------------
// bdq_store
// Ring element store: one ring address unit, one write port, registered read.
// ----------------------------------------------------------------------------
module bdq_store #(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                        i_clk,
    input  logic [$clog2(CAPACITY)-1:0] i_head,
    input  logic [$clog2(CAPACITY)-1:0] i_pos,
    input  logic                        i_we,
    input  logic [ELEMENT_BITS-1:0]     i_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_slot,
    output logic [ELEMENT_BITS-1:0]     o_rdata
);

    localparam int AW = $clog2(CAPACITY);

    logic [ELEMENT_BITS-1:0] r_mem [CAPACITY];
    logic [AW:0]             sum;

    // head + pos, folded back once into the ring
    always_comb begin
        sum = {1'b0, i_head} + {1'b0, i_pos};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        o_slot = sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[o_slot] <= i_wdata;
        end
        o_rdata <= r_mem[o_slot];
    end

endmodule

// ----- sv/bounded_deque_with_sort.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_sort
// Bounded double-ended queue of signed words in a ring store, with sort.
// ----------------------------------------------------------------------------
// Command channel: a word on i_cmd is taken at a clock edge with start high
// and busy low. Each command gives exactly one result word on o_rsp, shown
// for one cycle with o_done high; the receiver cannot stall it. busy drops
// in the same cycle o_done rises, so the next command can start then.
// Every command goes through the single ring address unit and the store's
// one access per cycle. Push, a failing command, a no-op and a sort of at
// most one element finish in the execute state; pop and read also wait
// for the registered read; swap reads a and b, then writes a and b.
// The sort carries the larger element along each pass and writes the
// smaller back; each compare has a read state and a compare-and-write state.
// Reset (synchronous, i_rst_n low) empties the queue and drops any command
// in flight; store contents are not cleared and are never read before they
// are written.
// ----------------------------------------------------------------------------
module bounded_deque_with_sort #(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bdq_pkg::t_cmd i_cmd,
    output logic          o_done,
    output bdq_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int WB = (ELEMENT_BITS > 32) ? ELEMENT_BITS : 32;

    bdq_pkg::t_state r_state, n_state;
    bdq_pkg::t_cmd   r_cmd;
    bdq_pkg::t_rsp   r_rsp, n_rsp;
    logic            r_done, n_done;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_last, n_last;
    logic [ELEMENT_BITS-1:0] r_carry, n_carry;
    logic [ELEMENT_BITS-1:0] r_hold, n_hold;

    logic [AW-1:0]           m_pos;
    logic                    m_we;
    logic [ELEMENT_BITS-1:0] m_wdata;
    logic [AW-1:0]           slot;
    logic [ELEMENT_BITS-1:0] rdata;

    logic                    ok_a, ok_b;
    logic [XW-1:0]           idx_a_m1, idx_b_m1;
    logic signed [WB-1:0]    v_in, v_out;
    logic                    is_full, is_empty, less;

    bdq_store #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_head  (r_head),
        .i_pos   (m_pos),
        .i_we    (m_we),
        .i_wdata (m_wdata),
        .o_slot  (slot),
        .o_rdata (rdata)
    );

    assign busy   = (r_state != bdq_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_comb begin
        ok_a     = (r_cmd.index_a != 7'd0) && (XW'(r_cmd.index_a) <= XW'(r_count));
        ok_b     = (r_cmd.index_b != 7'd0) && (XW'(r_cmd.index_b) <= XW'(r_count));
        idx_a_m1 = XW'(r_cmd.index_a) - XW'(1);
        idx_b_m1 = XW'(r_cmd.index_b) - XW'(1);
        v_in     = WB'($signed(r_cmd.value));
        v_out    = WB'($signed(rdata));
        is_full  = (r_count == CW'(CAPACITY));
        is_empty = (r_count == '0);
        less     = ($signed(rdata) < $signed(r_carry));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
            r_done  <= 1'b0;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_rsp   <= n_rsp;
        r_i     <= n_i;
        r_last  <= n_last;
        r_carry <= n_carry;
        r_hold  <= n_hold;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        n_head  = r_head;
        n_count = r_count;
        n_i     = r_i;
        n_last  = r_last;
        n_carry = r_carry;
        n_hold  = r_hold;
        m_pos   = '0;
        m_we    = 1'b0;
        m_wdata = r_carry;

        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (start) begin
                    n_state = bdq_pkg::S_EXEC;
                end
            end

            bdq_pkg::S_EXEC: begin
                // default: finish now with ok / zero value
                n_done           = 1'b1;
                n_state          = bdq_pkg::S_IDLE;
                n_rsp.read_value = '0;
                n_rsp.status     = bdq_pkg::ST_OK;
                unique case (r_cmd.operation) inside
                    bdq_pkg::OP_PUSH_BACK: begin
                        if (is_full) begin
                            n_rsp.status = bdq_pkg::ST_FULL;
                        end else begin
                            m_pos   = AW'(r_count);
                            m_we    = 1'b1;
                            m_wdata = v_in[ELEMENT_BITS-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end
                    bdq_pkg::OP_PUSH_FRONT: begin
                        if (is_full) begin
                            n_rsp.status = bdq_pkg::ST_FULL;
                        end else begin
                            // head + CAPACITY-1 wraps to head - 1
                            m_pos   = AW'(CAPACITY - 1);
                            m_we    = 1'b1;
                            m_wdata = v_in[ELEMENT_BITS-1:0];
                            n_head  = slot;
                            n_count = r_count + CW'(1);
                        end
                    end
                    bdq_pkg::OP_POP_BACK, bdq_pkg::OP_POP_FRONT: begin
                        if (is_empty) begin
                            n_rsp.status = bdq_pkg::ST_EMPTY;
                        end else begin
                            n_done  = 1'b0;
                            n_state = bdq_pkg::S_RD_WAIT;
                            n_count = r_count - CW'(1);
                            if (r_cmd.operation == bdq_pkg::OP_POP_BACK) begin
                                m_pos = AW'(r_count - CW'(1));
                            end else begin
                                m_pos  = '0;
                                n_head = (r_head == AW'(CAPACITY - 1)) ? '0
                                                                       : r_head + AW'(1);
                            end
                        end
                    end
                    bdq_pkg::OP_READ: begin
                        if (!ok_a) begin
                            n_rsp.status = bdq_pkg::ST_RANGE;
                        end else begin
                            n_done  = 1'b0;
                            n_state = bdq_pkg::S_RD_WAIT;
                            m_pos   = idx_a_m1[AW-1:0];
                        end
                    end
                    bdq_pkg::OP_SWAP: begin
                        if (!ok_a || !ok_b) begin
                            n_rsp.status = bdq_pkg::ST_RANGE;
                        end else begin
                            n_done  = 1'b0;
                            n_state = bdq_pkg::S_SWP_B;
                            m_pos   = idx_a_m1[AW-1:0];
                        end
                    end
                    bdq_pkg::OP_SORT: begin
                        if (r_count > CW'(1)) begin
                            n_done  = 1'b0;
                            n_state = bdq_pkg::S_SRT_LOAD;
                            m_pos   = '0;
                            n_i     = '0;
                            n_last  = AW'(r_count - CW'(1));
                        end
                    end
                    default: begin
                    end
                endcase
                n_rsp.count = 7'(n_count);
            end

            bdq_pkg::S_RD_WAIT: begin
                n_done           = 1'b1;
                n_state          = bdq_pkg::S_IDLE;
                n_rsp.read_value = v_out[31:0];
                n_rsp.count      = 7'(r_count);
                n_rsp.status     = bdq_pkg::ST_OK;
            end

            // swap: read a, read b, write a <- b, write b <- a
            bdq_pkg::S_SWP_B: begin
                m_pos   = idx_b_m1[AW-1:0];
                n_hold  = rdata;
                n_state = bdq_pkg::S_SWP_WA;
            end

            bdq_pkg::S_SWP_WA: begin
                m_pos   = idx_a_m1[AW-1:0];
                m_we    = 1'b1;
                m_wdata = rdata;
                n_state = bdq_pkg::S_SWP_WB;
            end

            bdq_pkg::S_SWP_WB: begin
                m_pos            = idx_b_m1[AW-1:0];
                m_we             = 1'b1;
                m_wdata          = r_hold;
                n_done           = 1'b1;
                n_state          = bdq_pkg::S_IDLE;
                n_rsp.read_value = '0;
                n_rsp.count      = 7'(r_count);
                n_rsp.status     = bdq_pkg::ST_OK;
            end

            bdq_pkg::S_SRT_PASS: begin
                m_pos   = '0;
                n_i     = '0;
                n_state = bdq_pkg::S_SRT_LOAD;
            end

            bdq_pkg::S_SRT_LOAD: begin
                m_pos   = r_i + AW'(1);
                n_carry = rdata;
                n_state = bdq_pkg::S_SRT_CMP;
            end

            bdq_pkg::S_SRT_RD: begin
                m_pos   = r_i + AW'(1);
                n_state = bdq_pkg::S_SRT_CMP;
            end

            // smaller word goes back at i, larger one travels on
            bdq_pkg::S_SRT_CMP: begin
                m_pos = r_i;
                m_we  = 1'b1;
                if (less) begin
                    m_wdata = rdata;
                end else begin
                    m_wdata = r_carry;
                    n_carry = rdata;
                end
                n_i     = r_i + AW'(1);
                n_state = (r_i + AW'(1) == r_last) ? bdq_pkg::S_SRT_TAIL
                                                   : bdq_pkg::S_SRT_RD;
            end

            bdq_pkg::S_SRT_TAIL: begin
                m_pos   = r_i;
                m_we    = 1'b1;
                m_wdata = r_carry;
                n_last  = r_last - AW'(1);
                if (r_last == AW'(1)) begin
                    n_done           = 1'b1;
                    n_state          = bdq_pkg::S_IDLE;
                    n_rsp.read_value = '0;
                    n_rsp.count      = 7'(r_count);
                    n_rsp.status     = bdq_pkg::ST_OK;
                end else begin
                    n_state = bdq_pkg::S_SRT_PASS;
                end
            end

            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
    parameter int CAPACITY = 64
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input bdq_pkg::t_rsp o_rsp
);

    // every command passes through the execute state after idle, so results never abut
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result words back to back");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == bdq_pkg::ST_FULL) |-> (o_rsp.count == 7'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == bdq_pkg::ST_EMPTY)
            |-> (o_rsp.count == 7'd0 && o_rsp.read_value == 32'sd0))
        else $error("empty status with nonzero count or value");

endmodule

bind bounded_deque_with_sort bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
